// ===== hw/rtl/sha256_pkg.sv =====
// SHA-256 constants and payload types shared across the hasher.
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int BLOCK_BYTES = 64;
    localparam int PAD_LEN_POS = 56;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        begin
            unique case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level: byte-streaming SHA-256 hasher with buffer, schedule and round engine.
`default_nettype none
// Takes one message byte per transfer (command absorb) and, on a finish
// command, pads the message and returns the eight digest words as eight
// result transfers, index 0 first, then starts over for the next message.
// The 64th byte of a block starts a compression that holds off input: the
// block is loaded as 16 words from the byte buffer, the working variables
// are fetched from the hash memory, 64 rounds run (one round per cycle,
// schedule words kept in a 16-word shift line), and the results are added
// into the hash memory. A finish writes the padding bytes one per cycle (64
// minus the fill count), runs one compression, or two with another 64-byte
// padding block when 56 or more bytes are buffered, then reads out each
// digest word, waiting on any result stall.
module sha256_stream_hasher (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sha256_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sha256_pkg::out_item_t      m_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PAD   = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_HINIT = 4'd3;
    localparam logic [3:0] ST_ROUND = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_OUT   = 4'd6;
    localparam logic [3:0] ST_RESET = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] len_reg, len_next;
    logic        fin_reg, fin_next;      // finishing a message
    logic        second_reg, second_next; // padding needs an extra block
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic        m_valid_reg, m_valid_next;
    sha256_pkg::out_item_t m_data_reg, m_data_next;
    logic        hinit_reg, hinit_next;   // hash memory holds init values

    // byte buffer
    logic       bb_we;
    logic [5:0] bb_wa, bb_ra;
    logic [7:0] bb_wd, bb_rd;
    sha256_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .aclk(aclk), .wr_en(bb_we), .wr_addr(bb_wa), .wr_data(bb_wd),
        .rd_addr(bb_ra), .rd_data(bb_rd)
    );

    // hash words
    logic        h_we;
    logic [2:0]  h_wa, h_ra;
    logic [31:0] h_wd, h_rd;
    sha256_ram #(.WIDTH(32), .DEPTH(8)) u_hash (
        .aclk(aclk), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
        .rd_addr(h_ra), .rd_data(h_rd)
    );

    // Schedule taps w[t-16], w[t-15], w[t-7], w[t-2] kept in a 16-deep shift
    // line, so each round needs no read port.
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] s0, s1, wt, t1, t2, ch, maj, sig0, sig1;

    always_comb begin
        s0 = sha256_pkg::rotr(win_reg[1], 7) ^ sha256_pkg::rotr(win_reg[1], 18)
             ^ (win_reg[1] >> 3);
        s1 = sha256_pkg::rotr(win_reg[14], 17) ^ sha256_pkg::rotr(win_reg[14], 19)
             ^ (win_reg[14] >> 10);
        wt = (cnt_reg < 7'd16) ? win_reg[cnt_reg[3:0]]
                               : s1 + win_reg[9] + s0 + win_reg[0];
        sig1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
               ^ sha256_pkg::rotr(v_reg[4], 25);
        sig0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
               ^ sha256_pkg::rotr(v_reg[0], 22);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + sig1 + ch + sha256_pkg::round_k(cnt_reg[5:0]) + wt;
        t2 = sig0 + maj;
    end

    always_comb begin
        logic [63:0] len_now;
        logic [7:0]  pad_byte;
        logic [5:0]  pidx;
        state_next = state_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        len_next = len_reg;
        fin_next = fin_reg;
        second_next = second_reg;
        cnt_next = cnt_reg;
        word_next = word_reg;
        hinit_next = hinit_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        for (int i = 0; i < 8; i++) v_next[i] = v_reg[i];
        for (int i = 0; i < 16; i++) win_next[i] = win_reg[i];
        s_ready = 1'b0;
        bb_we = 1'b0; bb_wa = fill_reg; bb_wd = s_data.data_byte;
        bb_ra = 6'd0;
        h_we = 1'b0; h_wa = cnt_reg[2:0]; h_wd = 32'd0; h_ra = cnt_reg[2:0];
        len_now = bits_reg + {55'd0, fill_reg, 3'd0};
        pidx = cnt_reg[5:0];
        pad_byte = 8'h00;
        if (pidx >= 6'(sha256_pkg::PAD_LEN_POS) && !second_reg) begin
            pad_byte = len_reg[8'(63 - 8 * (pidx - 6'(sha256_pkg::PAD_LEN_POS))) -: 8];
        end else if (pidx == fill_reg && !(second_reg && fin_reg && cnt_reg[6])) begin
            pad_byte = 8'h80;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.command == sha256_pkg::CMD_ABSORB) begin
                        bb_we = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            bits_next = bits_reg + 64'd512;
                            fin_next = 1'b0;
                            cnt_next = 7'd0;
                            state_next = ST_LOAD;
                        end
                    end else begin
                        len_next = len_now;
                        fin_next = 1'b1;
                        second_next = (fill_reg >= 6'(sha256_pkg::PAD_LEN_POS));
                        cnt_next = {1'b0, fill_reg};
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // cnt walks from the fill point to 63; 0x80 at the fill point
                bb_we = 1'b1;
                bb_wa = cnt_reg[5:0];
                bb_wd = pad_byte;
                if (cnt_reg[5:0] == 6'd63) begin
                    cnt_next = 7'd0;
                    state_next = ST_LOAD;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_LOAD: begin
                // read bytes 0..63, one per cycle; assemble on the next
                bb_ra = cnt_reg[5:0];
                if (cnt_reg != 7'd0) begin
                    word_next = {word_reg[23:0], bb_rd};
                    if (cnt_reg[1:0] == 2'd0) begin
                        win_next[cnt_reg[5:2] - 4'd1] = {word_reg[23:0], bb_rd};
                    end
                end
                if (cnt_reg == 7'd64) begin
                    cnt_next = 7'd0;
                    state_next = ST_HINIT;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_HINIT: begin
                // fetch working variables from the hash memory
                h_ra = cnt_reg[2:0];
                if (cnt_reg != 7'd0) begin
                    v_next[cnt_reg[2:0] - 3'd1] = hinit_reg
                        ? sha256_pkg::init_hash(cnt_reg[2:0] - 3'd1) : h_rd;
                end
                if (cnt_reg == 7'd8) begin
                    cnt_next = 7'd0;
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND: begin
                if (cnt_reg >= 7'd16) begin
                    for (int i = 0; i < 15; i++) win_next[i] = win_reg[i + 1];
                    win_next[15] = wt;
                end
                v_next[7] = v_reg[6]; v_next[6] = v_reg[5]; v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2]; v_next[2] = v_reg[1]; v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                if (cnt_reg == 7'd63) begin
                    cnt_next = 7'd0;
                    state_next = ST_ADD;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ADD: begin
                // cnt 0..7 reads hash word, cnt 1..8 writes sum
                h_ra = cnt_reg[2:0];
                if (cnt_reg != 7'd0) begin
                    h_we = 1'b1;
                    h_wa = cnt_reg[2:0] - 3'd1;
                    h_wd = (hinit_reg ? sha256_pkg::init_hash(cnt_reg[2:0] - 3'd1) : h_rd)
                           + v_reg[cnt_reg[2:0] - 3'd1];
                end
                if (cnt_reg == 7'd8) begin
                    hinit_next = 1'b0;
                    cnt_next = 7'd0;
                    if (!fin_reg) begin
                        fill_next = 6'd0;
                        state_next = ST_IDLE;
                    end else if (second_reg) begin
                        second_next = 1'b0;
                        fill_next = 6'd0;
                        cnt_next = 7'd64; // marks the length-only block
                        state_next = ST_RESET;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_RESET: begin
                // zero-fill the second padding block, then append the length
                bb_we = 1'b1;
                bb_wa = cnt_reg[5:0];
                bb_wd = (cnt_reg[5:0] >= 6'(sha256_pkg::PAD_LEN_POS))
                    ? len_reg[8'(63 - 8 * (cnt_reg[5:0] - 6'(sha256_pkg::PAD_LEN_POS))) -: 8]
                    : 8'h00;
                if (cnt_reg[5:0] == 6'd63) begin
                    cnt_next = 7'd0;
                    state_next = ST_LOAD;
                end else begin
                    cnt_next = {1'b1, cnt_reg[5:0] + 6'd1};
                end
            end
            ST_OUT: begin
                // cnt 0 fetches word 0; later cycles emit when the slot is free
                h_ra = cnt_reg[2:0];
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (cnt_reg[3] == 1'b0 && (!m_valid_reg || m_ready) && word_reg[0]) begin
                    m_valid_next = 1'b1;
                    m_data_next.digest_word = h_rd;
                    m_data_next.word_index = cnt_reg[2:0];
                    m_data_next.last_word = (cnt_reg[2:0] == 3'd7);
                    word_next = 32'd0;
                    cnt_next = cnt_reg + 7'd1;
                end else if (cnt_reg[3] == 1'b0) begin
                    word_next = 32'd1; // read data valid next cycle
                end
                if (cnt_reg[3] && (!m_valid_reg || m_ready)) begin
                    hinit_next = 1'b1;
                    bits_next = 64'd0;
                    fill_next = 6'd0;
                    fin_next = 1'b0;
                    cnt_next = 7'd0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg != ST_OUT && m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg <= 6'd0;
            bits_reg <= 64'd0;
            fin_reg <= 1'b0;
            second_reg <= 1'b0;
            cnt_reg <= 7'd0;
            hinit_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            word_reg <= 32'd0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            fin_reg <= fin_next;
            second_reg <= second_next;
            cnt_reg <= cnt_next;
            hinit_reg <= hinit_next;
            m_valid_reg <= m_valid_next;
            word_reg <= word_next;
        end
        len_reg <= len_next;
        m_data_reg <= m_data_next;
        for (int i = 0; i < 8; i++) v_reg[i] <= v_next[i];
        for (int i = 0; i < 16; i++) win_reg[i] <= win_next[i];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sha256_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== bench/tb_sha256_stream_hasher.sv =====
// Testbench for the byte-streaming SHA-256 hasher: directed and random messages vs. a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_stream_hasher;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sha256_pkg::in_item_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sha256_pkg::out_item_t m_data;

    sha256_stream_hasher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] hw [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] msg_bits;
    sha256_pkg::out_item_t digest_q[$];

    int errors = 0;
    int words_seen = 0;
    int msgs_done = 0;
    int bytes_sent = 0;
    int items_sent = 0;
    bit calm = 1'b0;

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        v = hw;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hw[i] += v[i];
    endtask

    function automatic void restart();
        hw = IV;
        fill = 0;
        msg_bits = '0;
    endfunction

    task automatic predict_hash(sha256_pkg::in_item_t it);
        logic [63:0] len;
        sha256_pkg::out_item_t dw;
        if (it.command == sha256_pkg::CMD_ABSORB) begin
            blk[fill] = it.data_byte;
            fill++;
            if (fill == sha256_pkg::BLOCK_BYTES) begin
                compress();
                msg_bits += 64'd512;
                fill = 0;
            end
            return;
        end
        len = msg_bits + 64'(fill * 8);
        blk[fill] = 8'h80;
        for (int i = fill + 1; i < sha256_pkg::BLOCK_BYTES; i++) blk[i] = 8'h00;
        if (fill >= sha256_pkg::PAD_LEN_POS) begin
            compress();
            for (int i = 0; i < sha256_pkg::PAD_LEN_POS; i++) blk[i] = 8'h00;
        end
        for (int b = 0; b < 8; b++) blk[sha256_pkg::PAD_LEN_POS + b] = len[63 - 8*b -: 8];
        compress();
        for (int k = 0; k < 8; k++) begin
            dw.digest_word = hw[k];
            dw.word_index = 3'(k);
            dw.last_word = (k == 7);
            digest_q.push_back(dw);
        end
        restart();
    endtask

    // result checking
    always @(posedge aclk) begin
        sha256_pkg::out_item_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected digest word %h", m_data);
            end else begin
                exp_w = digest_q.pop_front();
                if (m_data !== exp_w) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp word=%h idx=%0d last=%b, got word=%h idx=%0d last=%b",
                                 exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                                 m_data.digest_word, m_data.word_index, m_data.last_word);
                end
            end
        end
    end

    // result-side stalls
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send(sha256_pkg::in_item_t it);
        int n;
        // no idling in the tail of the run
        if (items_sent >= 125) calm = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_hash(it);
        items_sent++;
        if (it.command == sha256_pkg::CMD_FINISH) msgs_done++;
        else bytes_sent++;
    endtask

    task automatic send_msg(int nbytes);
        for (int j = 0; j < nbytes; j++)
            send('{command: sha256_pkg::CMD_ABSORB, data_byte: 8'($urandom)});
        send('{command: sha256_pkg::CMD_FINISH, data_byte: 8'($urandom)});
    endtask

    typedef struct {
        logic       command;
        logic [7:0] data_byte;
        bit         has_known;
        logic [31:0] known_w0;
    } row_t;

    // directed rows: "abc", empty message, data extremes
    row_t rows [$] = '{
        '{sha256_pkg::CMD_FINISH, 8'hff, 1'b1, 32'he3b0c442},
        '{sha256_pkg::CMD_ABSORB, 8'h61, 1'b0, '0},
        '{sha256_pkg::CMD_ABSORB, 8'h62, 1'b0, '0},
        '{sha256_pkg::CMD_ABSORB, 8'h63, 1'b0, '0},
        '{sha256_pkg::CMD_FINISH, 8'h00, 1'b1, 32'hba7816bf},
        '{sha256_pkg::CMD_ABSORB, 8'h00, 1'b0, '0},
        '{sha256_pkg::CMD_ABSORB, 8'hff, 1'b0, '0},
        '{sha256_pkg::CMD_ABSORB, 8'haa, 1'b0, '0},
        '{sha256_pkg::CMD_ABSORB, 8'h55, 1'b0, '0},
        '{sha256_pkg::CMD_FINISH, 8'h5a, 1'b0, '0}
    };

    initial begin
        restart();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[r]) begin
            send('{command: rows[r].command, data_byte: rows[r].data_byte});
            if (rows[r].has_known) begin
                // known first digest word for the standard short vectors
                if (digest_q[digest_q.size() - 8].digest_word !== rows[r].known_w0) begin
                    errors++;
                    if (errors <= 10)
                        $display("known vector row %0d: predictor %h exp %h", r,
                                 digest_q[digest_q.size() - 8].digest_word, rows[r].known_w0);
                end
            end
        end
        // one full block, then 56 bytes so the length spills into an extra block
        send_msg(120);
        // short random messages
        while (items_sent < 135)
            send_msg($urandom_range(0, 6));
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d messages, %0d data bytes, %0d digest words checked",
                 msgs_done, bytes_sent, words_seen);
        if (errors == 0 && digest_q.size() == 0)
            $display("SUCCESS");
        else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_ram.sv
hw/rtl/sha256_stream_hasher.sv
bench/tb_sha256_stream_hasher.sv
